// File: design/gcdist_pkg.sv
// Shared types, constants and the arctangent table for the great-circle distance block.
// Used by gcdist_cos, gcdist_sqrt and great_circle_distance; depends on nothing.
`default_nettype none

package gcdist_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 20;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam int LAT_W = 28;
	localparam int LON_W = 29;
	localparam int DIST_W = 25;
	localparam int RADIUS_W = 23;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378137;

	// Angles and angle differences are widened to this many bits before the cosine.
	localparam int ANG_W = 30;

	// CORDIC datapath width, Q2.30 with headroom.
	localparam int CW = 34;
	typedef logic signed [CW-1:0] cordic_t;

	localparam cordic_t ONE_Q30 = cordic_t'(34'd1073741824);
	localparam cordic_t CORDIC_GAIN_Q30 = cordic_t'(34'd652032874);
	localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;

	// Square root of a Q2.30 value shifted left by 30.
	localparam int SQ_IN_W = 31;
	localparam int SQ_ROOT_W = 31;
	localparam int SQ_STEPS = 31;
	localparam logic [SQ_IN_W-1:0] ONE_SQ = 31'd1073741824;

	function automatic cordic_t atan_q30(input int idx);
		cordic_t a;
		case (idx)
			0: a = cordic_t'(32'h3243F6A8);
			1: a = cordic_t'(32'h1DAC6705);
			2: a = cordic_t'(32'h0FADBAFC);
			3: a = cordic_t'(32'h07F56EA6);
			4: a = cordic_t'(32'h03FEAB76);
			5: a = cordic_t'(32'h01FFD55B);
			6: a = cordic_t'(32'h00FFFAAA);
			7: a = cordic_t'(32'h007FFF55);
			8: a = cordic_t'(32'h003FFFEA);
			9: a = cordic_t'(32'h001FFFFD);
			10: a = cordic_t'(32'h000FFFFF);
			11: a = cordic_t'(32'h0007FFFF);
			12: a = cordic_t'(32'h0003FFFF);
			13: a = cordic_t'(32'h0001FFFF);
			14: a = cordic_t'(32'h0000FFFF);
			15: a = cordic_t'(32'h00007FFF);
			16: a = cordic_t'(32'h00003FFF);
			17: a = cordic_t'(32'h00001FFF);
			18: a = cordic_t'(32'h00000FFF);
			19: a = cordic_t'(32'h000007FF);
			20: a = cordic_t'(32'h000003FF);
			21: a = cordic_t'(32'h000001FF);
			22: a = cordic_t'(32'h000000FF);
			23: a = cordic_t'(32'h0000007F);
			24: a = cordic_t'(32'h0000003F);
			25: a = cordic_t'(32'h0000001F);
			26: a = cordic_t'(32'h0000000F);
			27: a = cordic_t'(32'h00000008);
			28: a = cordic_t'(32'h00000004);
			29: a = cordic_t'(32'h00000002);
			30: a = cordic_t'(32'h00000001);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// File: design/gcdist_cos.sv
// Pipelined cosine of a signed angle in scaled degrees: range reduction, radian
// conversion and one rotation-mode CORDIC step per stage. Depends on gcdist_pkg.
`default_nettype none

module gcdist_cos #(
	parameter int ANGLE_FRAC_BITS = gcdist_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = gcdist_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [gcdist_pkg::ANG_W-1:0] angle,
	output gcdist_pkg::cordic_t                 cos_val
);

	localparam int AW = gcdist_pkg::ANG_W;
	localparam int CW = gcdist_pkg::CW;
	localparam int UW = (ANGLE_FRAC_BITS + 9 > AW) ? ANGLE_FRAC_BITS + 9 : AW;
	localparam logic [63:0] TURN = 64'd360 << ANGLE_FRAC_BITS;
	localparam logic [63:0] RECIP = (64'd1 << AW) / TURN;
	localparam int RW = $clog2(RECIP + 64'd2);
	localparam int UFW = ANGLE_FRAC_BITS + 7;
	localparam int PW = UFW + 31;
	localparam logic [UW-1:0] TURN_U = UW'(TURN);
	localparam logic [UW-1:0] HALF_U = UW'(64'd180 << ANGLE_FRAC_BITS);
	localparam logic [UW-1:0] QUARTER_U = UW'(64'd90 << ANGLE_FRAC_BITS);

	logic [AW-1:0] mag;
	logic [AW-1:0] u_s1;
	logic [AW-1:0] u_s2;
	logic [AW+RW-1:0] prod_s2;
	logic [RW-1:0] quo;
	logic [UW-1:0] r0_s3;
	logic [UW-1:0] r_s4;
	logic [UW-1:0] r_half;
	logic [UW-1:0] r_fold;
	logic fold_neg;
	logic [UFW-1:0] uf_s5;
	logic neg_s5;
	logic [PW-1:0] p_s6;
	logic neg_s6;
	logic [PW-1:0] p_rnd;
	gcdist_pkg::cordic_t rot_x_s [0:CORDIC_STEPS];
	gcdist_pkg::cordic_t rot_y_s [0:CORDIC_STEPS];
	gcdist_pkg::cordic_t rot_z_s [0:CORDIC_STEPS];
	logic rot_neg_s [0:CORDIC_STEPS];
	gcdist_pkg::cordic_t cos_out_s;

	assign mag = angle[AW-1] ? AW'(-angle) : AW'(angle);
	assign quo = prod_s2[AW+RW-1:AW];

	// Fold the reduced angle into the first quadrant; the second quadrant flips the sign.
	always_comb begin
		r_half = (r_s4 > HALF_U) ? TURN_U - r_s4 : r_s4;
		fold_neg = r_half > QUARTER_U;
		r_fold = fold_neg ? HALF_U - r_half : r_half;
	end

	assign p_rnd = p_s6 + (PW'(1) << (ANGLE_FRAC_BITS + 5));

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= mag;
			u_s2 <= u_s1;
			// The reciprocal estimate of the quotient is low by at most one.
			prod_s2 <= (AW+RW)'(u_s1) * (AW+RW)'(RECIP[RW-1:0]);
			r0_s3 <= UW'(u_s2) - UW'(UW'(quo) * TURN_U);
			r_s4 <= (r0_s3 >= TURN_U) ? r0_s3 - TURN_U : r0_s3;
			uf_s5 <= r_fold[UFW-1:0];
			neg_s5 <= fold_neg;
			p_s6 <= PW'(uf_s5) * PW'(gcdist_pkg::DEG2RAD_Q36);
			neg_s6 <= neg_s5;
			rot_x_s[0] <= gcdist_pkg::CORDIC_GAIN_Q30;
			rot_y_s[0] <= '0;
			rot_z_s[0] <= CW'(p_rnd[ANGLE_FRAC_BITS + 6 +: 31]);
			rot_neg_s[0] <= neg_s6;
			cos_out_s <= rot_neg_s[CORDIC_STEPS] ? -rot_x_s[CORDIC_STEPS]
				: rot_x_s[CORDIC_STEPS];
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		localparam gcdist_pkg::cordic_t ATAN_K = gcdist_pkg::atan_q30(k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!rot_z_s[k][CW-1]) begin
					rot_x_s[k+1] <= rot_x_s[k] - (rot_y_s[k] >>> k);
					rot_y_s[k+1] <= rot_y_s[k] + (rot_x_s[k] >>> k);
					rot_z_s[k+1] <= rot_z_s[k] - ATAN_K;
				end else begin
					rot_x_s[k+1] <= rot_x_s[k] + (rot_y_s[k] >>> k);
					rot_y_s[k+1] <= rot_y_s[k] - (rot_x_s[k] >>> k);
					rot_z_s[k+1] <= rot_z_s[k] + ATAN_K;
				end
				rot_neg_s[k+1] <= rot_neg_s[k];
			end
		end
	end

	assign cos_val = cos_out_s;

endmodule

`default_nettype wire

// File: design/gcdist_sqrt.sv
// Pipelined floor square root of a Q2.30 value shifted left by 30, one root bit per
// stage. Depends on gcdist_pkg.
`default_nettype none

module gcdist_sqrt (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [gcdist_pkg::SQ_IN_W-1:0]          val,
	output logic [gcdist_pkg::SQ_ROOT_W-1:0]        root
);

	localparam int STEPS = gcdist_pkg::SQ_STEPS;
	localparam int RTW = gcdist_pkg::SQ_ROOT_W;
	localparam int RADW = 2 * STEPS;
	localparam int REMW = RTW + 3;

	logic [RADW-1:0] rad_s [1:STEPS];
	logic [REMW-1:0] rem_s [1:STEPS];
	logic [RTW-1:0] root_s [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [RADW-1:0] rad_i;
		logic [REMW-1:0] rem_i;
		logic [RTW-1:0] root_i;
		logic [REMW-1:0] rem_n;
		logic [REMW-1:0] trial;

		if (k == 0) begin : g_first
			assign rad_i = RADW'({val, 30'd0});
			assign rem_i = '0;
			assign root_i = '0;
		end else begin : g_next
			assign rad_i = rad_s[k];
			assign rem_i = rem_s[k];
			assign root_i = root_s[k];
		end

		assign rem_n = {rem_i[REMW-3:0], rad_i[RADW-1:RADW-2]};
		assign trial = REMW'({root_i, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_i << 2;
				if (rem_n >= trial) begin
					rem_s[k+1] <= rem_n - trial;
					root_s[k+1] <= {root_i[RTW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_n;
					root_s[k+1] <= {root_i[RTW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[STEPS];

endmodule

`default_nettype wire

// File: design/great_circle_distance.sv
// Throughput: one transaction per cycle; every stage is a register, and a stall on the
// output freezes the whole pipeline without loss.
// Reset clears all valid bits and loads the earth radius with 6378137 m.
// Holds the top level and the haversine, arctangent and scaling stages; depends on
// gcdist_pkg, gcdist_cos and gcdist_sqrt.
`default_nettype none

module great_circle_distance #(
	parameter int ANGLE_FRAC_BITS = gcdist_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = gcdist_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [gcdist_pkg::RADIUS_W-1:0]        cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [gcdist_pkg::LAT_W-1:0]    lat_a,
	input  logic signed [gcdist_pkg::LON_W-1:0]    lon_a,
	input  logic signed [gcdist_pkg::LAT_W-1:0]    lat_b,
	input  logic signed [gcdist_pkg::LON_W-1:0]    lon_b,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [gcdist_pkg::DIST_W-1:0]          distance_m
);

	localparam int AW = gcdist_pkg::ANG_W;
	localparam int CW = gcdist_pkg::CW;
	localparam int COS_LAT = CORDIC_STEPS + 8;
	localparam int IDX_H = COS_LAT + 2;
	localparam int IDX_SQ = IDX_H + gcdist_pkg::SQ_STEPS;
	localparam int LAT = IDX_SQ + CORDIC_STEPS + 3;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [gcdist_pkg::RADIUS_W-1:0] radius_q;

	logic signed [AW-1:0] ang_dlat, ang_dlon, ang_la, ang_lb;
	gcdist_pkg::cordic_t c_dlat, c_dlon, c_la, c_lb;
	gcdist_pkg::cordic_t hav_lat_d, hav_lon_d;
	logic signed [31:0] c_la_t, c_lb_t;

	logic signed [31:0] hav_lat_s1, hav_lon_s1;
	logic signed [63:0] ccp_s1;
	logic signed [31:0] cc;
	logic signed [31:0] hav_lat_s2;
	logic signed [63:0] p2_s2;
	logic signed [31:0] p2_hi;
	gcdist_pkg::cordic_t hsum;
	logic [gcdist_pkg::SQ_IN_W-1:0] h_s3;

	logic [gcdist_pkg::SQ_ROOT_W-1:0] sq_y, sq_x;

	gcdist_pkg::cordic_t vec_x_s [1:CORDIC_STEPS];
	gcdist_pkg::cordic_t vec_y_s [1:CORDIC_STEPS];
	gcdist_pkg::cordic_t vec_z_s [1:CORDIC_STEPS];

	logic [30:0] zc;
	logic [53:0] dprod_s4;
	logic [55:0] drnd;
	logic [gcdist_pkg::DIST_W-1:0] dist_s5;

	logic [63:0] sq_sum;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			radius_q <= gcdist_pkg::RADIUS_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], in_valid};
			end
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
		end
	end

	assign ang_la = AW'(lat_a);
	assign ang_lb = AW'(lat_b);
	assign ang_dlat = AW'(lat_a) - AW'(lat_b);
	assign ang_dlon = AW'(lon_a) - AW'(lon_b);

	gcdist_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cos_dlat (
		.clk(clk), .en(en), .angle(ang_dlat), .cos_val(c_dlat)
	);
	gcdist_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cos_dlon (
		.clk(clk), .en(en), .angle(ang_dlon), .cos_val(c_dlon)
	);
	gcdist_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cos_la (
		.clk(clk), .en(en), .angle(ang_la), .cos_val(c_la)
	);
	gcdist_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cos_lb (
		.clk(clk), .en(en), .angle(ang_lb), .cos_val(c_lb)
	);

	// Cosines stay within about one in Q2.30, so 32 bits carry them into the multipliers.
	assign c_la_t = c_la[31:0];
	assign c_lb_t = c_lb[31:0];
	assign hav_lat_d = (gcdist_pkg::ONE_Q30 - c_dlat) >>> 1;
	assign hav_lon_d = (gcdist_pkg::ONE_Q30 - c_dlon) >>> 1;
	assign cc = ccp_s1[61:30];
	assign p2_hi = p2_s2[61:30];
	assign hsum = CW'(hav_lat_s2) + CW'(p2_hi);

	always_ff @(posedge clk) begin
		if (en) begin
			hav_lat_s1 <= hav_lat_d[31:0];
			hav_lon_s1 <= hav_lon_d[31:0];
			ccp_s1 <= c_la_t * c_lb_t;
			hav_lat_s2 <= hav_lat_s1;
			p2_s2 <= cc * hav_lon_s1;
			if (hsum[CW-1]) begin
				h_s3 <= '0;
			end else if (hsum > gcdist_pkg::ONE_Q30) begin
				h_s3 <= gcdist_pkg::ONE_SQ;
			end else begin
				h_s3 <= hsum[gcdist_pkg::SQ_IN_W-1:0];
			end
		end
	end

	gcdist_sqrt u_sqrt_y (
		.clk(clk), .en(en), .val(h_s3), .root(sq_y)
	);
	gcdist_sqrt u_sqrt_x (
		.clk(clk), .en(en), .val(gcdist_pkg::ONE_SQ - h_s3), .root(sq_x)
	);

	// Vectoring CORDIC: the angle of (sqrt(1-h), sqrt(h)) is half the central angle.
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
		localparam gcdist_pkg::cordic_t ATAN_K = gcdist_pkg::atan_q30(k);
		gcdist_pkg::cordic_t vx, vy, vz;

		if (k == 0) begin : g_first
			assign vx = CW'(sq_x);
			assign vy = CW'(sq_y);
			assign vz = '0;
		end else begin : g_next
			assign vx = vec_x_s[k];
			assign vy = vec_y_s[k];
			assign vz = vec_z_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!vy[CW-1]) begin
					vec_x_s[k+1] <= vx + (vy >>> k);
					vec_y_s[k+1] <= vy - (vx >>> k);
					vec_z_s[k+1] <= vz + ATAN_K;
				end else begin
					vec_x_s[k+1] <= vx - (vy >>> k);
					vec_y_s[k+1] <= vy + (vx >>> k);
					vec_z_s[k+1] <= vz - ATAN_K;
				end
			end
		end
	end

	assign zc = vec_z_s[CORDIC_STEPS][CW-1] ? '0 : vec_z_s[CORDIC_STEPS][30:0];
	assign drnd = {dprod_s4, 1'b0} + (56'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s4 <= 54'(radius_q) * 54'(zc);
			dist_s5 <= drnd[54:30];
		end
	end

	assign distance_m = dist_s5;

	assign sq_sum = 64'(sq_y) * 64'(sq_y) + 64'(sq_x) * 64'(sq_x);

	a_h_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[IDX_H] |-> h_s3 <= gcdist_pkg::ONE_SQ)
		else $error("haversine value left the unit range after clamping");

	a_roots_unit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[IDX_SQ] |-> (sq_sum <= (64'd1 << 60)) && (sq_sum >= (64'd1 << 60) - (64'd1 << 32)))
		else $error("square roots of h and 1-h do not form a unit vector");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

endmodule

`default_nettype wire

// File: tb/great_circle_distance_tb.sv
// Self-checking bench for great_circle_distance: random and corner point pairs,
// fixed-point haversine predictor, random stalls on both channels.
// Depends on gcdist_pkg and the great_circle_distance RTL.
`timescale 1ns / 100ps
`default_nettype none

module great_circle_distance_tb;

	localparam int FRAC = 20;
	localparam int STEPS = 24;
	localparam longint TURN = 360 * (64'sd1 << FRAC);
	localparam longint HALF = 180 * (64'sd1 << FRAC);
	localparam longint QUARTER = 90 * (64'sd1 << FRAC);
	localparam longint ONE = 64'sd1 << 30;
	localparam longint LAT_MAX = 94371840;
	localparam longint LON_MAX = 188743680;
	localparam int LATENCY = 2 * STEPS + 44;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [gcdist_pkg::LAT_W-1:0] la;
		logic [gcdist_pkg::LON_W-1:0] oa;
		logic [gcdist_pkg::LAT_W-1:0] lb;
		logic [gcdist_pkg::LON_W-1:0] ob;
	} point_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [gcdist_pkg::RADIUS_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [gcdist_pkg::LAT_W-1:0] lat_a = '0;
	logic signed [gcdist_pkg::LON_W-1:0] lon_a = '0;
	logic signed [gcdist_pkg::LAT_W-1:0] lat_b = '0;
	logic signed [gcdist_pkg::LON_W-1:0] lon_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [gcdist_pkg::DIST_W-1:0] distance_m;

	point_pair_t pending_pairs[$];
	logic [gcdist_pkg::DIST_W-1:0] expected_dist[$];
	longint radius_m = gcdist_pkg::RADIUS_RESET;
	int fail_count = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_off = 0;

	great_circle_distance i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.out_valid(out_valid), .out_stall(out_stall), .distance_m(distance_m)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint atan_step(int i);
		return longint'(gcdist_pkg::atan_q30(i));
	endfunction

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	// Cosine in Q2.30 of a signed angle in scaled degrees, folded into one quadrant.
	function automatic longint cos_scaled(longint a);
		longint u, x, y, z, dx, dy;
		bit neg;
		u = (a < 0) ? -a : a;
		u = u % TURN;
		neg = 1'b0;
		if (u > HALF)
			u = TURN - u;
		if (u > QUARTER) begin
			u = HALF - u;
			neg = 1'b1;
		end
		z = (u * longint'(gcdist_pkg::DEG2RAD_Q36) + (64'sd1 << (FRAC + 5))) >>> (FRAC + 6);
		x = longint'(gcdist_pkg::CORDIC_GAIN_Q30);
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		return neg ? -x : x;
	endfunction

	function automatic longint floor_root(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [gcdist_pkg::DIST_W-1:0] haversine_metres(point_pair_t p);
		longint la, oa, lb, ob, hl, ho, cc, h, x, y, z, dx, dy, d;
		la = longint'($signed(p.la));
		oa = longint'($signed(p.oa));
		lb = longint'($signed(p.lb));
		ob = longint'($signed(p.ob));
		hl = asr(ONE - cos_scaled(la - lb), 1);
		ho = asr(ONE - cos_scaled(oa - ob), 1);
		cc = asr(cos_scaled(la) * cos_scaled(lb), 30);
		h = hl + asr(cc * ho, 30);
		if (h < 0)
			h = 0;
		if (h > ONE)
			h = ONE;
		y = floor_root(h << 30);
		x = floor_root((ONE - h) << 30);
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		if (z < 0)
			z = 0;
		d = (radius_m * z * 2 + (64'sd1 << 29)) >>> 30;
		return d[gcdist_pkg::DIST_W-1:0];
	endfunction

	function automatic longint rand_span(longint lim);
		return longint'($urandom_range(32'd0, 32'(2 * lim))) - lim;
	endfunction

	function automatic point_pair_t rand_pair();
		point_pair_t p;
		if ($urandom_range(0, 9) == 0) begin
			// Raw bit patterns, far outside the nominal ranges.
			p.la = gcdist_pkg::LAT_W'($urandom);
			p.oa = gcdist_pkg::LON_W'($urandom);
			p.lb = gcdist_pkg::LAT_W'($urandom);
			p.ob = gcdist_pkg::LON_W'($urandom);
		end else if ($urandom_range(0, 4) == 0) begin
			// Near-antipodal and near-identical points stress the clamps.
			p.la = gcdist_pkg::LAT_W'(rand_span(LAT_MAX));
			p.oa = gcdist_pkg::LON_W'(rand_span(LON_MAX));
			if ($urandom_range(0, 1)) begin
				p.lb = gcdist_pkg::LAT_W'(-$signed(p.la) + rand_span(64));
				p.ob = gcdist_pkg::LON_W'($signed(p.oa) + HALF + rand_span(64));
			end else begin
				p.lb = gcdist_pkg::LAT_W'($signed(p.la) + rand_span(16));
				p.ob = gcdist_pkg::LON_W'($signed(p.oa) + rand_span(16));
			end
		end else begin
			p.la = gcdist_pkg::LAT_W'(rand_span(LAT_MAX));
			p.oa = gcdist_pkg::LON_W'(rand_span(LON_MAX));
			p.lb = gcdist_pkg::LAT_W'(rand_span(LAT_MAX));
			p.ob = gcdist_pkg::LON_W'(rand_span(LON_MAX));
		end
		return p;
	endfunction

	// Sender: presents the head of the pending queue, idling at random.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_dist.insert(expected_dist.size(),
				haversine_metres({lat_a, lon_a, lat_b, lon_b}));
			void'(pending_pairs.pop_front());
		end
		if (!in_valid || !in_stall) begin
			if (pending_pairs.size() != 0 && arst_n
			    && (in_quiet || $urandom_range(0, 99) >= 26)) begin
				in_valid <= 1'b1;
				lat_a <= pending_pairs[0].la;
				lon_a <= pending_pairs[0].oa;
				lat_b <= pending_pairs[0].lb;
				lon_b <= pending_pairs[0].ob;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// One long receiver hold-off, started once on request and counted down here.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end else if (hold_go && !hold_done) begin
			hold_off <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver: checks each result in order, with random stalls, plus the long hold-off while the sender keeps going.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_dist.size() == 0) begin
				$error("distance_m: unexpected transaction, actual %0d", distance_m);
				fail_count++;
			end else begin
				if (distance_m !== expected_dist[0]) begin
					$error("distance_m: expected %0d, actual %0d", expected_dist[0],
					       distance_m);
					fail_count++;
				end
				void'(expected_dist.pop_front());
			end
		end
		if (hold_off > 0) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= !out_quiet && ($urandom_range(0, 99) < 26);
		end
	end

	task automatic drain_and_wait();
		while (pending_pairs.size() != 0 || in_valid || expected_dist.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_radius(logic [gcdist_pkg::RADIUS_W-1:0] r);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_m = r;
	endtask

	task automatic add_pending(point_pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	task automatic push_pair(longint la, longint oa, longint lb, longint ob);
		add_pending({gcdist_pkg::LAT_W'(la), gcdist_pkg::LON_W'(oa),
			gcdist_pkg::LAT_W'(lb), gcdist_pkg::LON_W'(ob)});
	endtask

	initial begin
		logic [gcdist_pkg::RADIUS_W-1:0] radii[5];
		radii = '{23'd6000000, 23'd6500000, 23'd0, 23'h7FFFFF, 23'd6371000};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the reset radius.
		push_pair(0, 0, 0, 0);
		push_pair(LAT_MAX, 0, -LAT_MAX, 0);
		push_pair(0, -LON_MAX, 0, LON_MAX);
		push_pair(0, 0, 0, LON_MAX);
		push_pair(0, 0, 0, LON_MAX / 2);
		push_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		push_pair(-LAT_MAX, 12345, LAT_MAX, -54321);
		push_pair(-(64'sd1 << 27), -(64'sd1 << 28), (64'sd1 << 27) - 1, (64'sd1 << 28) - 1);
		push_pair((64'sd1 << 27) - 1, (64'sd1 << 28) - 1, -(64'sd1 << 27), -(64'sd1 << 28));
		push_pair(-1, -1, -1, -1);
		push_pair(1, 1, -1, -1);
		push_pair(10000000, 20000000, -10000000, 20000000 + HALF);
		push_pair(QUARTER + 7, TURN + 3, -QUARTER - 7, -TURN - 3);
		push_pair(45 << FRAC, 0, 45 << FRAC, 1);
		drain_and_wait();

		// Long receiver hold-off with no sender gaps so the pipeline fills.
		in_quiet = 1'b1;
		for (int i = 0; i < 200; i++)
			add_pending(rand_pair());
		hold_go = 1'b1;
		drain_and_wait();
		in_quiet = 1'b0;

		foreach (radii[k]) begin
			write_radius(radii[k]);
			out_quiet = (k == 4);
			for (int i = 0; i < 45; i++)
				add_pending(rand_pair());
			push_pair(LAT_MAX, 0, -LAT_MAX, 1);
			drain_and_wait();
		end
		out_quiet = 1'b0;

		if (fail_count == 0)
			$display("great_circle_distance verification clean");
		else
			$display("great_circle_distance verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("great_circle_distance verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
design/gcdist_pkg.sv
design/gcdist_cos.sv
design/gcdist_sqrt.sv
design/great_circle_distance.sv
tb/great_circle_distance_tb.sv
